### rtl/fpbs_pkg.sv
`default_nettype none
package fpbs_pkg;
	localparam int ID_W = 4;
	localparam int PER_W = 32;
	localparam int PRI_W = 16;
	localparam int MASK_W = 16;

	typedef enum logic [1:0] {
		CMD_CREATE   = 2'd0,
		CMD_ENQUEUE  = 2'd1,
		CMD_DEQUEUE  = 2'd2,
		CMD_SCHEDULE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STRAT_RM = 2'd0,
		STRAT_DM = 2'd1,
		STRAT_FP = 2'd2,
		STRAT_XX = 2'd3
	} strat_t;

	// sort keys that travel with an entry through the queue cells
	typedef struct packed {
		logic [PER_W-1:0] period;
		logic [PER_W-1:0] deadline;
		logic [PRI_W-1:0] prio;
	} key_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic       ins;
		logic       del;
		logic       upd;
		logic [5:0] id;
		key_t       key;
		strat_t     strat;
	} cell_ctl_t;
endpackage
`default_nettype wire

### rtl/fpbs_cell.sv
`default_nettype none
// one queue slot: holds an entry id and its sort key, shifts right on insert
// and left on delete
module fpbs_cell #(
	parameter int IDW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fpbs_pkg::cell_ctl_t ctl,
	input  wire logic              prev_valid,
	input  wire logic              prev_hit,
	input  wire logic [IDW-1:0]    prev_id,
	input  wire fpbs_pkg::key_t    prev_key,
	input  wire logic              prev_del,
	input  wire logic              next_valid,
	input  wire logic [IDW-1:0]    next_id,
	input  wire fpbs_pkg::key_t    next_key,
	output logic                   valid_q,
	output logic [IDW-1:0]         id_q,
	output fpbs_pkg::key_t         key_q,
	output logic                   hit,
	output logic                   del_here
);
	import fpbs_pkg::*;

	logic ahead;
	logic shift_in;
	logic shift_out;

	// new entry goes ahead of this one under the current order
	always_comb begin
		case (ctl.strat)
			STRAT_RM: ahead = ctl.key.period <= key_q.period;
			STRAT_DM: ahead = ctl.key.deadline <= key_q.deadline;
			default:  ahead = ctl.key.prio >= key_q.prio;
		endcase
	end

	// hit: insertion point at or before this slot
	assign hit = prev_hit | ~valid_q | ahead;
	assign del_here = prev_del | (valid_q && id_q == ctl.id[IDW-1:0]);
	assign shift_in = ctl.ins & hit;
	assign shift_out = ctl.del & del_here;

	// slot update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_in) begin
			valid_q <= prev_hit ? prev_valid : 1'b1;
		end else if (shift_out) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			if (prev_hit) begin
				id_q  <= prev_id;
				key_q <= prev_key;
			end else begin
				id_q  <= ctl.id[IDW-1:0];
				key_q <= ctl.key;
			end
		end else if (shift_out) begin
			id_q  <= next_id;
			key_q <= next_key;
		end else if (ctl.upd && valid_q && id_q == ctl.id[IDW-1:0]) begin
			// re-created entry keeps its place but takes the new key
			key_q <= ctl.key;
		end
	end
endmodule
`default_nettype wire

### rtl/fixed_priority_budget_scheduler.sv
`default_nettype none
// channel  | handshake          | payload
// input    | in_valid/in_stall  | cmd entry_id period_value deadline_value priority_value
//          |                    | budget_value now_time runnable_mask force_idle
// output   | out_valid/out_stall| status chosen_entry chose_idle
// config   | strategy_we        | strategy_wdata
// create, enqueue, dequeue: result the cycle after
// schedule: a walk over the queue chain; S_REFILL refills lapsed periods of the queued slots,
//   S_PICK steps up to the first runnable entry within budget, S_OUT gives the result
// reset clears the queue, running state and strategy; the table needs none
// a waiting result holds while out_stall is high; in_stall is high while busy or a result waits
module fixed_priority_budget_scheduler #(
	parameter int NUM_ENTRIES = 16,
	parameter int TIME_WIDTH  = 48
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                cmd,
	input  wire logic [3:0]                entry_id,
	input  wire logic [31:0]               period_value,
	input  wire logic [31:0]               deadline_value,
	input  wire logic [15:0]               priority_value,
	input  wire logic [31:0]               budget_value,
	input  wire logic [TIME_WIDTH-1:0]     now_time,
	input  wire logic [15:0]               runnable_mask,
	input  wire logic                      force_idle,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           status,
	output logic [3:0]                     chosen_entry,
	output logic                           chose_idle,
	input  wire logic                      strategy_we,
	input  wire logic [1:0]                strategy_wdata
);
	import fpbs_pkg::*;

	localparam int N   = NUM_ENTRIES;
	localparam int IDW = $clog2(NUM_ENTRIES);
	localparam int TW  = TIME_WIDTH;
	localparam int CW  = $clog2(NUM_ENTRIES + 1);

	typedef enum logic [1:0] {S_IDLE, S_REFILL, S_PICK, S_OUT} state_t;

	state_t state_q;
	strat_t strat_q;

	// entry table
	key_t            tab_key   [N];
	logic [31:0]     tab_budget[N];
	logic [TW-1:0]   tab_used  [N];
	logic [TW-1:0]   tab_next  [N];
	logic [TW-1:0]   tab_start [N];
	logic [N-1:0]    queued_q;

	logic [CW-1:0]   count_q;
	logic [IDW-1:0]  run_entry_q;
	logic            run_idle_q;

	// latched request
	logic [TW-1:0]   now_q;
	logic [15:0]     mask_q;
	logic            force_q;
	logic [CW-1:0]   walk_q;
	logic            found_q;
	logic [IDW-1:0]  pick_q;

	logic            status_q;
	logic [3:0]      chosen_q;
	logic            idle_q;

	// queue chain
	logic            c_valid[N];
	logic [IDW-1:0]  c_id   [N];
	key_t            c_key  [N];
	logic            c_hit  [N];
	logic            c_del  [N];
	cell_ctl_t       ctl;

	logic accept;
	logic id_ok;
	logic [5:0] id_ext;
	logic [IDW-1:0] idx;
	logic [IDW-1:0] walk_e;
	logic walk_live;
	logic run_ok;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != S_IDLE) | out_valid;
	assign id_ext   = {2'b00, entry_id};
	assign id_ok    = {1'b0, id_ext} < 7'(N);
	assign idx      = IDW'(entry_id);

	// control to cells
	always_comb begin
		ctl.ins   = accept && cmd == CMD_ENQUEUE && id_ok && !queued_q[idx]
			&& count_q < CW'(N);
		ctl.del   = accept && cmd == CMD_DEQUEUE && id_ok && queued_q[idx];
		ctl.upd   = accept && cmd == CMD_CREATE && id_ok;
		ctl.id    = id_ext;
		if (cmd == CMD_CREATE) begin
			ctl.key = '{period: period_value, deadline: deadline_value,
				prio: priority_value};
		end else begin
			ctl.key = tab_key[idx];
		end
		ctl.strat = strat_q;
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic pv, ph, pd, nv;
			logic [IDW-1:0] pi, ni;
			key_t pk, nk;
			if (g == 0) begin : g_first
				assign pv = 1'b1; assign ph = 1'b0; assign pd = 1'b0;
				assign pi = '0;   assign pk = '0;
			end else begin : g_mid
				assign pv = c_valid[g-1]; assign ph = c_hit[g-1];
				assign pd = c_del[g-1];
				assign pi = c_id[g-1];    assign pk = c_key[g-1];
			end
			if (g == N-1) begin : g_last
				assign nv = 1'b0; assign ni = '0; assign nk = '0;
			end else begin : g_tail
				assign nv = c_valid[g+1]; assign ni = c_id[g+1];
				assign nk = c_key[g+1];
			end
			fpbs_cell #(.IDW(IDW)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.prev_valid(pv), .prev_hit(ph), .prev_id(pi), .prev_key(pk),
				.prev_del(pd), .next_valid(nv), .next_id(ni), .next_key(nk),
				.valid_q(c_valid[g]), .id_q(c_id[g]), .key_q(c_key[g]),
				.hit(c_hit[g]), .del_here(c_del[g])
			);
		end
	endgenerate

	// walk pointer picks one slot at a time
	assign walk_e    = c_id[walk_q[IDW-1:0]];
	assign walk_live = walk_q < count_q;
	assign run_ok    = ({{(32-IDW){1'b0}}, walk_e} < 32'd16) &&
		mask_q[4'(walk_e)] && (tab_used[walk_e] < TW'(tab_budget[walk_e]));

	// strategy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strat_q <= STRAT_RM;
		end else if (strategy_we && strategy_wdata != STRAT_XX) begin
			strat_q <= strat_t'(strategy_wdata);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid   <= 1'b0;
			queued_q    <= '0;
			count_q     <= '0;
			run_entry_q <= '0;
			run_idle_q  <= 1'b1;
			walk_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_SCHEDULE) begin
							state_q <= S_REFILL;
							walk_q  <= '0;
							found_q <= 1'b0;
						end else begin
							out_valid <= 1'b1;
						end
						if (ctl.ins) begin
							queued_q[idx] <= 1'b1;
							count_q       <= count_q + 1'b1;
						end
						if (ctl.del) begin
							queued_q[idx] <= 1'b0;
							count_q       <= count_q - 1'b1;
						end
					end
				end
				S_REFILL: begin
					if (walk_live) begin
						walk_q <= walk_q + 1'b1;
					end else begin
						walk_q  <= '0;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (walk_live && !run_ok) begin
						walk_q <= walk_q + 1'b1;
					end else begin
						found_q <= walk_live;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					state_q   <= S_IDLE;
					out_valid <= 1'b1;
					if (found_q && !force_q) begin
						run_idle_q  <= 1'b0;
						run_entry_q <= pick_q;
					end else begin
						run_idle_q  <= 1'b1;
						run_entry_q <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload, table and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= now_time;
			mask_q   <= runnable_mask;
			force_q  <= force_idle;
			status_q <= 1'b0;
			chosen_q <= '0;
			idle_q   <= 1'b0;
			if (cmd == CMD_SCHEDULE) begin
				// charge the running entry
				if (!run_idle_q) begin
					tab_used[run_entry_q] <= tab_used[run_entry_q] +
						(now_time - tab_start[run_entry_q]);
				end
			end else if (!id_ok) begin
				status_q <= 1'b1;
			end else if (cmd == CMD_CREATE) begin
				tab_key[idx]    <= '{period: period_value, deadline: deadline_value,
					prio: priority_value};
				tab_budget[idx] <= budget_value;
				tab_used[idx]   <= '0;
				tab_start[idx]  <= '0;
				tab_next[idx]   <= now_time + TW'(period_value);
			end else if (cmd == CMD_ENQUEUE) begin
				status_q <= ~ctl.ins;
			end else begin
				status_q <= ~ctl.del;
			end
		end
		if (state_q == S_REFILL && walk_live && now_q > tab_next[walk_e]) begin
			tab_used[walk_e] <= '0;
			tab_next[walk_e] <= now_q + TW'(tab_key[walk_e].period);
		end
		if (state_q == S_PICK && walk_live && run_ok) begin
			tab_start[walk_e] <= now_q;
			pick_q            <= walk_e;
		end
		if (state_q == S_OUT) begin
			if (found_q && !force_q) begin
				chosen_q <= 4'(pick_q);
				idle_q   <= 1'b0;
			end else begin
				chosen_q <= '0;
				idle_q   <= 1'b1;
			end
		end
	end

	assign status       = status_q;
	assign chosen_entry = chosen_q;
	assign chose_idle   = idle_q;

`ifndef ASSERT_OFF
	// queue count agrees with the queued flags
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(queued_q)))
		else $error("queue count out of step");
	// no request accepted during a schedule walk
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !accept)
		else $error("request accepted while busy");
	// an idle choice never names an entry
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chose_idle |-> chosen_entry == '0)
		else $error("idle result names an entry");
`endif
endmodule
`default_nettype wire

### verif/tb_fixed_priority_budget_scheduler.sv
`default_nettype none
module tb_fixed_priority_budget_scheduler;
	import fpbs_pkg::*;

	localparam int N_ENT = 16;
	localparam int DRAIN_CYCLES = 48;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [1:0]  cmd;
		logic [3:0]  id;
		logic [31:0] period;
		logic [31:0] deadline;
		logic [15:0] prio;
		logic [31:0] budget;
		logic [47:0] now;
		logic [15:0] mask;
		logic        force_idle;
	} sched_req_t;

	typedef struct {
		logic       status;
		logic [3:0] chosen;
		logic       idle;
	} sched_outcome_t;

	// shadow of the task table and run queue, predicts one outcome per request
	class sched_scoreboard;
		logic [31:0] t_period[N_ENT];
		logic [31:0] t_deadline[N_ENT];
		logic [15:0] t_prio[N_ENT];
		logic [31:0] t_budget[N_ENT];
		logic [47:0] t_used[N_ENT];
		logic [47:0] t_next[N_ENT];
		logic [47:0] t_start[N_ENT];
		bit          t_queued[N_ENT];
		int          run_queue[$];
		int          cur_entry;
		bit          cur_idle;
		strat_t      order_rule;
		sched_outcome_t expected_outcomes[$];
		int          errors;
		int          n_checked;
		int          n_picked;
		int          n_idle;

		function new();
			for (int i = 0; i < N_ENT; i++) begin
				t_period[i] = '0; t_deadline[i] = '0; t_prio[i] = '0; t_budget[i] = '0;
				t_used[i] = '0; t_next[i] = '0; t_start[i] = '0; t_queued[i] = 0;
			end
			cur_entry = 0;
			cur_idle = 1;
			order_rule = STRAT_RM;
			errors = 0;
			n_checked = 0;
			n_picked = 0;
			n_idle = 0;
		endfunction

		function void set_order_rule(logic [1:0] v);
			// the reserved code leaves the rule as it was
			if (v != STRAT_XX)
				order_rule = strat_t'(v);
		endfunction

		function bit ranks_ahead(int a, int b);
			case (order_rule)
				STRAT_RM: return t_period[a] <= t_period[b];
				STRAT_DM: return t_deadline[a] <= t_deadline[b];
				default:  return t_prio[a] >= t_prio[b];
			endcase
		endfunction

		function void note_request(sched_req_t r);
			sched_outcome_t o;
			int pos;
			int e;
			int pick;
			bit found;
			o = '{1'b0, 4'd0, 1'b0};
			case (r.cmd)
				CMD_SCHEDULE: begin
					// charge the running entry, refill lapsed periods, then pick
					if (!cur_idle)
						t_used[cur_entry] = t_used[cur_entry] + (r.now - t_start[cur_entry]);
					foreach (run_queue[k]) begin
						e = run_queue[k];
						if (r.now > t_next[e]) begin
							t_used[e] = '0;
							t_next[e] = r.now + t_period[e];
						end
					end
					found = 0;
					pick = 0;
					foreach (run_queue[k]) begin
						e = run_queue[k];
						if (!found && r.mask[e] && t_used[e] < {16'd0, t_budget[e]}) begin
							found = 1;
							pick = e;
							t_start[e] = r.now;
						end
					end
					if (found && !r.force_idle) begin
						cur_idle = 0;
						cur_entry = pick;
						o.chosen = pick[3:0];
						n_picked++;
					end else begin
						cur_idle = 1;
						cur_entry = 0;
						o.idle = 1'b1;
						n_idle++;
					end
				end
				CMD_CREATE: begin
					t_period[r.id] = r.period;
					t_deadline[r.id] = r.deadline;
					t_prio[r.id] = r.prio;
					t_budget[r.id] = r.budget;
					t_used[r.id] = '0;
					t_start[r.id] = '0;
					t_next[r.id] = r.now + r.period;
				end
				CMD_ENQUEUE: begin
					if (t_queued[r.id] || run_queue.size() >= N_ENT) begin
						o.status = 1'b1;
					end else begin
						pos = 0;
						while (pos < run_queue.size() && !ranks_ahead(r.id, run_queue[pos]))
							pos++;
						run_queue.insert(pos, int'(r.id));
						t_queued[r.id] = 1;
					end
				end
				default: begin
					if (!t_queued[r.id]) begin
						o.status = 1'b1;
					end else begin
						for (int k = run_queue.size() - 1; k >= 0; k--)
							if (run_queue[k] == r.id)
								run_queue.delete(k);
						t_queued[r.id] = 0;
					end
				end
			endcase
			expected_outcomes.push_back(o);
		endfunction

		function void check_result(logic st, logic [3:0] ch, logic idl);
			sched_outcome_t o;
			if (expected_outcomes.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			o = expected_outcomes.pop_front();
			n_checked++;
			if (st !== o.status) begin
				$error("status expected %0d actual %0d", o.status, st);
				errors++;
			end
			if (ch !== o.chosen) begin
				$error("chosen_entry expected %0d actual %0d", o.chosen, ch);
				errors++;
			end
			if (idl !== o.idle) begin
				$error("chose_idle expected %0d actual %0d", o.idle, idl);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [3:0]  entry_id;
	logic [31:0] period_value;
	logic [31:0] deadline_value;
	logic [15:0] priority_value;
	logic [31:0] budget_value;
	logic [47:0] now_time;
	logic [15:0] runnable_mask;
	logic        force_idle;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [3:0]  chosen_entry;
	logic        chose_idle;
	logic        strategy_we;
	logic [1:0]  strategy_wdata;

	sched_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_asks;
	int  hold_seen;
	int  hold_left;
	int  quiet_cycles;
	int  n_sent;
	logic [47:0] time_base;

	fixed_priority_budget_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .entry_id(entry_id),
		.period_value(period_value), .deadline_value(deadline_value),
		.priority_value(priority_value), .budget_value(budget_value),
		.now_time(now_time), .runnable_mask(runnable_mask), .force_idle(force_idle),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .chosen_entry(chosen_entry), .chose_idle(chose_idle),
		.strategy_we(strategy_we), .strategy_wdata(strategy_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// receiver: random stall, or a long hold counted here
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(status, chosen_entry, chose_idle);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL fixed_priority_budget_scheduler");
				$finish;
			end
		end
	end

	function automatic sched_req_t mk_req(logic [1:0] c, logic [3:0] id, logic [31:0] per,
			logic [31:0] dl, logic [15:0] pri, logic [31:0] bud, logic [47:0] now,
			logic [15:0] mask, logic fi);
		sched_req_t r;
		r.cmd = c; r.id = id; r.period = per; r.deadline = dl; r.prio = pri;
		r.budget = bud; r.now = now; r.mask = mask; r.force_idle = fi;
		return r;
	endfunction

	// offer one request and wait until it is taken
	task automatic send_req(sched_req_t r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd <= r.cmd;
		entry_id <= r.id;
		period_value <= r.period;
		deadline_value <= r.deadline;
		priority_value <= r.prio;
		budget_value <= r.budget;
		now_time <= r.now;
		runnable_mask <= r.mask;
		force_idle <= r.force_idle;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
		n_sent++;
		@(negedge clk);
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain_block();
		in_valid <= 1'b0;
		while (sb.expected_outcomes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_order_rule(logic [1:0] v);
		strategy_we <= 1'b1;
		strategy_wdata <= v;
		@(negedge clk);
		strategy_we <= 1'b0;
		sb.set_order_rule(v);
	endtask

	function automatic sched_req_t random_req();
		sched_req_t r;
		int sel;
		sel = $urandom_range(0, 99);
		r.cmd = (sel < 40) ? CMD_SCHEDULE : (sel < 65) ? CMD_ENQUEUE :
			(sel < 85) ? CMD_DEQUEUE : CMD_CREATE;
		r.id = 4'($urandom_range(0, 15));
		sel = $urandom_range(0, 99);
		r.period = (sel < 70) ? $urandom_range(1, 3000) : (sel < 85) ? $urandom :
			(sel < 92) ? 32'd0 : 32'hFFFF_FFFF;
		r.deadline = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
		r.prio = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		sel = $urandom_range(0, 99);
		r.budget = (sel < 75) ? $urandom_range(0, 800) : (sel < 90) ? $urandom :
			32'hFFFF_FFFF;
		// mostly a steadily advancing clock, sometimes a jump anywhere
		sel = $urandom_range(0, 99);
		if (sel < 85)
			time_base = time_base + 48'($urandom_range(0, 1500));
		else if (sel < 95)
			time_base = 48'({$urandom, $urandom});
		r.now = time_base;
		r.mask = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'hFFFF ^ (16'd1 << $urandom_range(0, 15));
		r.force_idle = ($urandom_range(0, 99) < 15);
		return r;
	endfunction

	initial begin
		strat_t phase_rule[6];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cmd = CMD_CREATE;
		entry_id = '0;
		period_value = '0;
		deadline_value = '0;
		priority_value = '0;
		budget_value = '0;
		now_time = '0;
		runnable_mask = '0;
		force_idle = 1'b0;
		strategy_we = 1'b0;
		strategy_wdata = STRAT_RM;
		send_idle_pct = 13;
		recv_idle_pct = 84;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;
		quiet_cycles = 0;
		n_sent = 0;
		time_base = '0;
		phase_rule = '{STRAT_RM, STRAT_FP, STRAT_DM, STRAT_XX, STRAT_FP, STRAT_RM};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extreme entries, duplicates, forced idle, empty mask, wrap
		send_req(mk_req(CMD_CREATE, 4'd0, 32'd0, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF,
			48'd0, 16'd0, 1'b0));
		send_req(mk_req(CMD_CREATE, 4'd15, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'd0,
			48'hFFFF_FFFF_FFFF, 16'd0, 1'b0));
		for (int i = 1; i < 15; i++)
			send_req(mk_req(CMD_CREATE, i[3:0], 100 * i, 50 * (15 - i), i[15:0], 60,
				48'd10, 16'd0, 1'b0));
		send_req(mk_req(CMD_ENQUEUE, 4'd0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_req(mk_req(CMD_ENQUEUE, 4'd15, 0, 0, 0, 0, 0, 0, 1'b0));
		send_req(mk_req(CMD_ENQUEUE, 4'd3, 0, 0, 0, 0, 0, 0, 1'b0));
		send_req(mk_req(CMD_ENQUEUE, 4'd3, 0, 0, 0, 0, 0, 0, 1'b0));
		send_req(mk_req(CMD_DEQUEUE, 4'd7, 0, 0, 0, 0, 0, 0, 1'b0));
		send_req(mk_req(CMD_SCHEDULE, 4'd0, 0, 0, 0, 0, 48'd100, 16'hFFFF, 1'b1));
		send_req(mk_req(CMD_SCHEDULE, 4'd0, 0, 0, 0, 0, 48'd120, 16'h0000, 1'b0));
		send_req(mk_req(CMD_SCHEDULE, 4'd0, 0, 0, 0, 0, 48'd150, 16'h0008, 1'b0));
		send_req(mk_req(CMD_DEQUEUE, 4'd3, 0, 0, 0, 0, 0, 0, 1'b0));
		send_req(mk_req(CMD_SCHEDULE, 4'd0, 0, 0, 0, 0, 48'd400, 16'hFFFF, 1'b0));
		send_req(mk_req(CMD_CREATE, 4'd0, 32'd5, 32'd5, 16'd9, 32'd7, 48'd410, 0, 1'b0));
		send_req(mk_req(CMD_SCHEDULE, 4'd0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0));
		send_req(mk_req(CMD_SCHEDULE, 4'd0, 0, 0, 0, 0, 48'd20, 16'hFFFF, 1'b0));
		time_base = 48'd20;

		// random phases over the order rules and idling patterns
		for (int p = 0; p < 6; p++) begin
			drain_block();
			write_order_rule(phase_rule[p]);
			send_idle_pct = (p < 2) ? 13 : (p < 4) ? 84 : 0;
			recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 13 : 0;
			for (int i = 0; i < 290; i++) begin
				if (p == 4 && i == 50)
					hold_asks++;
				if (p == 2 && i == 100)
					drain_block();
				send_req(random_req());
			end
		end

		drain_block();
		$display("sent %0d requests, checked %0d results: %0d entry picks, %0d idle picks",
			n_sent, sb.n_checked, sb.n_picked, sb.n_idle);
		$display("all three queue order rules, the reserved rule code, forced idle and time wrap");
		if (sb.errors == 0)
			$display("PASS fixed_priority_budget_scheduler");
		else
			$display("FAIL fixed_priority_budget_scheduler");
		$finish;
	end
endmodule
`default_nettype wire
